### design/sle_pkg.sv
package sle_pkg;

  localparam int CAPACITY    = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam int ACTION_W    = 3;
  localparam int POS_W       = 9;
  localparam int VAL_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 9;

  localparam int IN_BITS     = ACTION_W + POS_W + VAL_W;
  localparam int OUT_BITS    = STATUS_W + OUT_CNT_W + VAL_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CMP_W       = (POS_W > CNT_W) ? POS_W + 1 : CNT_W + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_ERASE      = 3'd5,
    ACT_READ       = 3'd6,
    ACT_NOP        = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_LAST,
    S_UP_INS,
    S_DOWN,
    S_DOWN_LAST,
    S_RD_ISSUE,
    S_RD_CAP,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

endpackage

### design/sle_ram.sv
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sequential_list_engine_core.sv
// Push back, pop back, action 7 and failed requests finish at decode; read issues a store
// read and captures it; insert or push front at position p below the count n moves entries
// p..n-1 up, then writes the value, and at p = n writes it directly; erase or pop front moves
// the entries above p down. One beat at a time; a move shifts one entry per cycle in the store.
// Reset (rst, synchronous) clears the element count and the handshake state; the store is
// not cleared and no entry is read before it is written.
module sequential_list_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action [2:0], position [11:3], value [43:12], zero fill above
  input  logic [sle_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status [1:0], count [10:2], read_value [42:11], zero fill above
  output logic [sle_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import sle_pkg::*;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [ADDR_W-1:0]      ptr, ptr_next;
  logic [ADDR_W-1:0]      lim, lim_next;
  logic [ADDR_W-1:0]      wptr, wptr_next;
  logic [ADDR_W-1:0]      ins_addr, ins_addr_next;
  logic [DATA_WIDTH-1:0]  word, word_next;
  logic                   pend, pend_next;
  status_t                res_status, res_status_next;
  logic [VAL_W-1:0]       res_read, res_read_next;

  status_t                out_status;
  logic [OUT_CNT_W-1:0]   out_count;
  logic [VAL_W-1:0]       out_read;
  logic                   out_load;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  action_t                in_action;
  logic [POS_W-1:0]       in_pos;
  logic signed [VAL_W-1:0] in_value;
  logic [DATA_WIDTH-1:0]  in_word;
  logic                   accept;

  logic [CMP_W-1:0]       pos_x, cnt_x, ins_pos, del_pos;
  logic                   full, empty;

  state_t                 dec_dest;
  status_t                dec_status;
  cnt_op_t                dec_cnt;
  logic                   dec_we;
  logic [ADDR_W-1:0]      dec_waddr;
  logic [ADDR_W-1:0]      dec_ptr;
  logic [ADDR_W-1:0]      dec_lim;
  cnt_op_t                cnt_op;

  assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
  assign in_pos    = s_tdata[ACTION_W +: POS_W];
  assign in_value  = signed'(s_tdata[ACTION_W + POS_W +: VAL_W]);
  assign in_word   = DATA_WIDTH'(in_value);

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_load  = (state == S_FINISH) && (!m_tvalid || m_tready);

  assign pos_x   = CMP_W'(in_pos);
  assign cnt_x   = CMP_W'(count);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign ins_pos = (in_action == ACT_PUSH_FRONT) ? '0 : pos_x;
  assign del_pos = (in_action == ACT_POP_FRONT) ? '0 : pos_x;

  // request decode
  always_comb begin
    dec_dest   = S_FINISH;
    dec_status = ST_OK;
    dec_cnt    = CNT_KEEP;
    dec_we     = 1'b0;
    dec_waddr  = ADDR_W'(ins_pos);
    dec_ptr    = ADDR_W'(cnt_x - CMP_W'(1));
    dec_lim    = ADDR_W'(ins_pos);
    unique case (in_action)
      ACT_PUSH_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_we    = 1'b1;
          dec_waddr = ADDR_W'(count);
          dec_cnt   = CNT_INC;
        end
      end
      ACT_PUSH_FRONT, ACT_INSERT: begin
        if (ins_pos > cnt_x) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else if (ins_pos == cnt_x) begin
          dec_we  = 1'b1;
          dec_cnt = CNT_INC;
        end else begin
          dec_dest = S_UP;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_cnt = CNT_DEC;
        end
      end
      ACT_POP_FRONT, ACT_ERASE: begin
        dec_ptr = ADDR_W'(del_pos + CMP_W'(1));
        dec_lim = ADDR_W'(cnt_x - CMP_W'(1));
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (del_pos >= cnt_x) begin
          dec_status = ST_RANGE;
        end else if (del_pos + CMP_W'(1) == cnt_x) begin
          dec_cnt = CNT_DEC;
        end else begin
          dec_dest = S_DOWN;
        end
      end
      ACT_READ: begin
        dec_ptr = ADDR_W'(pos_x);
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_dest = S_RD_ISSUE;
        end
      end
      ACT_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept) state_next = dec_dest;
      S_UP:        if (ptr == lim) state_next = S_UP_LAST;
      S_UP_LAST:   state_next = S_UP_INS;
      S_UP_INS:    state_next = S_FINISH;
      S_DOWN:      if (ptr == lim) state_next = S_DOWN_LAST;
      S_DOWN_LAST: state_next = S_FINISH;
      S_RD_ISSUE:  state_next = S_RD_CAP;
      S_RD_CAP:    state_next = S_FINISH;
      S_FINISH:    if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    ptr_next        = ptr;
    lim_next        = lim;
    wptr_next       = wptr;
    ins_addr_next   = ins_addr;
    word_next       = word;
    pend_next       = 1'b0;
    res_status_next = res_status;
    res_read_next   = res_read;
    cnt_op          = CNT_KEEP;
    ram_we          = 1'b0;
    ram_waddr       = wptr;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = ptr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ptr_next        = dec_ptr;
          lim_next        = dec_lim;
          ins_addr_next   = ADDR_W'(ins_pos);
          word_next       = in_word;
          res_status_next = dec_status;
          res_read_next   = '0;
          cnt_op          = dec_cnt;
          ram_we          = dec_we;
          ram_waddr       = dec_waddr;
          ram_wdata       = in_word;
        end
      end
      S_UP: begin
        ram_re    = 1'b1;
        ram_we    = pend;
        ptr_next  = ptr - ADDR_W'(1);
        wptr_next = ptr + ADDR_W'(1);
        pend_next = 1'b1;
      end
      S_UP_LAST: begin
        ram_we = 1'b1;
      end
      S_UP_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ins_addr;
        ram_wdata = word;
        cnt_op    = CNT_INC;
      end
      S_DOWN: begin
        ram_re    = 1'b1;
        ram_we    = pend;
        ptr_next  = ptr + ADDR_W'(1);
        wptr_next = ptr - ADDR_W'(1);
        pend_next = 1'b1;
      end
      S_DOWN_LAST: begin
        ram_we = 1'b1;
        cnt_op = CNT_DEC;
      end
      S_RD_ISSUE: begin
        ram_re = 1'b1;
      end
      S_RD_CAP: begin
        res_read_next = VAL_W'(signed'(ram_rdata));
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cnt_op)
      CNT_INC: count_next = count + CNT_W'(1);
      CNT_DEC: count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    lim        <= lim_next;
    wptr       <= wptr_next;
    ins_addr   <= ins_addr_next;
    word       <= word_next;
    res_status <= res_status_next;
    res_read   <= res_read_next;
    if (out_load) begin
      out_status <= res_status;
      out_count  <= OUT_CNT_W'(count);
      out_read   <= res_read;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_read, out_count, out_status});

  sle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
